### hdl/qes_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qes_pkg
// shared widths, codes and item types of the quadratic equation solver
// ----------------------------------------------------------------------------
package qes_pkg;

  // number formats: coefficients and roots are signed Q16.16
  localparam int unsigned WordBits = 32;
  localparam int unsigned FracBits = 16;
  // discriminant magnitude, Q34.32
  localparam int unsigned DiscBits = 2 * WordBits + 2;
  // square root bits, one per sqrt cell
  localparam int unsigned RootBits = DiscBits / 2;
  // sqrt partial remainder
  localparam int unsigned SremBits = RootBits + 2;
  // numerator magnitude |nb +/- s|
  localparam int unsigned NumBits  = RootBits + 2;
  // divisor magnitude |2a| or |b|
  localparam int unsigned DenBits  = WordBits + 1;
  // division partial remainder
  localparam int unsigned DremBits = DenBits + 1;

  // outcome codes
  localparam logic [1:0] OUT_NONE = 2'd0;
  localparam logic [1:0] OUT_ONE  = 2'd1;
  localparam logic [1:0] OUT_TWO  = 2'd2;
  localparam logic [1:0] OUT_ALL  = 2'd3;

  // register indexes
  localparam logic REG_COEF_TOL = 1'b0;
  localparam logic REG_DISC_TOL = 1'b1;

  // case decision handed along the sqrt chain
  typedef struct packed {
    logic [1:0]                  outcome;
    logic                        zero_roots;
    logic                        use_s;
    logic signed [WordBits:0]    nb;
    logic                        den_neg;
    logic [DenBits-1:0]          den_mag;
  } sol_t;

  // two division lanes handed along the divider chain
  typedef struct packed {
    logic [1:0]                  outcome;
    logic                        zero_roots;
    logic                        neg1;
    logic                        neg2;
    logic                        pre1;
    logic                        pre2;
    logic [NumBits-1:0]          nm1;
    logic [NumBits-1:0]          nm2;
    logic [DenBits-1:0]          dm;
    logic [DremBits-1:0]         rem1;
    logic [DremBits-1:0]         rem2;
    logic [WordBits-1:0]         q1;
    logic [WordBits-1:0]         q2;
  } div_t;

  // magnitude of a signed word
  function automatic logic [WordBits-1:0] mag_word(input logic [WordBits-1:0] x);
    mag_word = x[WordBits-1] ? (~x + 1'b1) : x;
  endfunction

endpackage

### hdl/qes_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qes_sqrt_cell
// one restoring square root step, takes one bit pair of the discriminant
// ----------------------------------------------------------------------------
module qes_sqrt_cell #(
  parameter int unsigned PairIdx = 0
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                vld_i,
  input  logic [qes_pkg::SremBits-1:0]        rem_i,
  input  logic [qes_pkg::RootBits-1:0]        root_i,
  input  logic [qes_pkg::DiscBits-1:0]        disc_i,
  input  qes_pkg::sol_t                       sol_i,
  output logic                                vld_o,
  output logic [qes_pkg::SremBits-1:0]        rem_o,
  output logic [qes_pkg::RootBits-1:0]        root_o,
  output logic [qes_pkg::DiscBits-1:0]        disc_o,
  output qes_pkg::sol_t                       sol_o
);

  logic                                vld_q;
  logic [qes_pkg::SremBits-1:0]        rem_q, rem_d;
  logic [qes_pkg::RootBits-1:0]        root_q, root_d;
  logic [qes_pkg::DiscBits-1:0]        disc_q;
  qes_pkg::sol_t                       sol_q;
  logic [qes_pkg::SremBits+1:0]        trial;
  logic [qes_pkg::SremBits+1:0]        cand;

  // shift in the next pair and try the candidate
  always_comb begin
    trial = {rem_i, disc_i[2*PairIdx+1 -: 2]};
    cand  = {1'b0, root_i, 2'b01};
    if (trial >= cand) begin
      rem_d  = qes_pkg::SremBits'(trial - cand);
      root_d = {root_i[qes_pkg::RootBits-2:0], 1'b1};
    end else begin
      rem_d  = qes_pkg::SremBits'(trial);
      root_d = {root_i[qes_pkg::RootBits-2:0], 1'b0};
    end
  end

  // item valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      disc_q <= disc_i;
      sol_q  <= sol_i;
    end
  end

  assign vld_o  = vld_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign disc_o = disc_q;
  assign sol_o  = sol_q;

endmodule

### hdl/qes_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qes_div_cell
// one restoring division step for both root lanes, yields quotient bit BitIdx
// ----------------------------------------------------------------------------
module qes_div_cell #(
  parameter int unsigned BitIdx = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  qes_pkg::div_t div_i,
  output logic          vld_o,
  output qes_pkg::div_t div_o
);

  logic                            vld_q;
  qes_pkg::div_t                   div_q, div_d;
  logic                            bit1, bit2;
  logic [qes_pkg::DremBits:0]      t1, t2;

  // numerator bit brought down by this cell (low bits are the fraction shift)
  if (BitIdx >= qes_pkg::FracBits) begin : g_num_bit
    assign bit1 = div_i.nm1[BitIdx-qes_pkg::FracBits];
    assign bit2 = div_i.nm2[BitIdx-qes_pkg::FracBits];
  end else begin : g_zero_bit
    assign bit1 = 1'b0;
    assign bit2 = 1'b0;
  end

  // subtract the divisor where it fits
  always_comb begin
    div_d = div_i;
    t1    = {div_i.rem1, bit1};
    t2    = {div_i.rem2, bit2};
    if (t1 >= {2'b00, div_i.dm}) begin
      div_d.rem1 = qes_pkg::DremBits'(t1 - {2'b00, div_i.dm});
      div_d.q1   = {div_i.q1[qes_pkg::WordBits-2:0], 1'b1};
    end else begin
      div_d.rem1 = qes_pkg::DremBits'(t1);
      div_d.q1   = {div_i.q1[qes_pkg::WordBits-2:0], 1'b0};
    end
    if (t2 >= {2'b00, div_i.dm}) begin
      div_d.rem2 = qes_pkg::DremBits'(t2 - {2'b00, div_i.dm});
      div_d.q2   = {div_i.q2[qes_pkg::WordBits-2:0], 1'b1};
    end else begin
      div_d.rem2 = qes_pkg::DremBits'(t2);
      div_d.q2   = {div_i.q2[qes_pkg::WordBits-2:0], 1'b0};
    end
  end

  // item valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign vld_o = vld_q;
  assign div_o = div_q;

endmodule

### hdl/quadratic_equation_solver_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_equation_solver_core
// real roots of a*x^2 + b*x + c = 0 in signed Q16.16, fully pipelined
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one equation per item: a, b, c (Q16.16) in tdata.
//   m_axis returns one result per item: both roots in tdata, outcome and
//   saturation flag in tuser. results leave in the order items arrived.
//   the apb port holds the coefficient and discriminant zero tolerances;
//   write them only while no item is in flight.
// pipeline: 3 front stages, 33 sqrt cells, one numerator stage, 32 divider
//   cells and an output register lie between accept and result valid.
// throughput: one item per cycle unless the chain holds; sqrt and divider
//   chains retire one result bit per cell each; items follow cell by cell.
// stall: while a result sits in the output register and m_axis_tready is
//   low the whole chain holds and s_axis_tready drops; items in flight keep.
// reset: clears every valid bit and both tolerances; the chain comes up
//   empty and accepts an item as soon as reset is released.
// ----------------------------------------------------------------------------
module quadratic_equation_solver_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // equation items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // coef_quad, coef_lin, coef_const
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // root_first, root_second
  output logic [2:0]  m_axis_tuser,   // outcome[1:0], overflow
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned W  = qes_pkg::WordBits;
  localparam int unsigned NC = qes_pkg::RootBits;
  localparam int unsigned ND = qes_pkg::WordBits;

  // ---------------------------------------------------------------- registers
  logic [15:0] coef_tol_q;
  logic [31:0] disc_tol_q;
  logic        cfg_wr;
  logic        reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  // tolerance registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_tol_q <= '0;
      disc_tol_q <= '0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        qes_pkg::REG_COEF_TOL: coef_tol_q <= pwdata[15:0];
        qes_pkg::REG_DISC_TOL: disc_tol_q <= pwdata;
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_sel)
      qes_pkg::REG_COEF_TOL: prdata = {16'b0, coef_tol_q};
      qes_pkg::REG_DISC_TOL: prdata = disc_tol_q;
      default:               prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- flow
  logic out_vld_q;
  logic en;
  logic acc;

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;
  assign acc           = s_axis_tvalid && en;

  // ---------------------------------------------------------------- stage 1
  logic [W-1:0] a_in, b_in, c_in;
  logic [W-1:0] ma_in, mb_in, mc_in;
  logic         az_in, bz_in, cz_in;

  assign a_in  = s_axis_tdata[W-1:0];
  assign b_in  = s_axis_tdata[2*W-1:W];
  assign c_in  = s_axis_tdata[3*W-1:2*W];
  assign ma_in = qes_pkg::mag_word(a_in);
  assign mb_in = qes_pkg::mag_word(b_in);
  assign mc_in = qes_pkg::mag_word(c_in);
  assign az_in = ma_in <= W'(coef_tol_q);
  assign bz_in = mb_in <= W'(coef_tol_q);
  assign cz_in = mc_in <= W'(coef_tol_q);

  logic         vld1_q;
  logic [W-1:0] bb1_q, c1_q, ma1_q, mb1_q, mc1_q;
  logic         as1_q, az1_q, bz1_q, cz1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else if (en) begin
      vld1_q <= acc;
    end
  end

  // coefficient magnitudes and zero flags, b forced to zero when tiny
  always_ff @(posedge clk_i) begin
    if (en) begin
      bb1_q <= bz_in ? '0 : b_in;
      mb1_q <= bz_in ? '0 : mb_in;
      c1_q  <= c_in;
      ma1_q <= ma_in;
      mc1_q <= mc_in;
      as1_q <= a_in[W-1];
      az1_q <= az_in;
      bz1_q <= bz_in;
      cz1_q <= cz_in;
    end
  end

  // ---------------------------------------------------------------- stage 2
  logic           vld2_q;
  logic [2*W-1:0] bsq2_q, ac2_q;
  logic           acneg2_q;
  logic [W-1:0]   bb2_q, c2_q, ma2_q, mb2_q;
  logic           as2_q, az2_q, bz2_q, cz2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld2_q <= 1'b0;
    end else if (en) begin
      vld2_q <= vld1_q;
    end
  end

  // b squared and |a*c|
  always_ff @(posedge clk_i) begin
    if (en) begin
      bsq2_q   <= mb1_q * mb1_q;
      ac2_q    <= ma1_q * mc1_q;
      acneg2_q <= (as1_q != c1_q[W-1]) && (ma1_q != '0) && (mc1_q != '0);
      bb2_q    <= bb1_q;
      c2_q     <= c1_q;
      ma2_q    <= ma1_q;
      mb2_q    <= mb1_q;
      as2_q    <= as1_q;
      az2_q    <= az1_q;
      bz2_q    <= bz1_q;
      cz2_q    <= cz1_q;
    end
  end

  // ---------------------------------------------------------------- stage 3
  logic [qes_pkg::DiscBits-1:0] l4, bsqx, disc_d;
  logic [qes_pkg::DiscBits:0]   diff;
  logic                         dneg_d;

  // discriminant as sign and magnitude
  always_comb begin
    l4   = {ac2_q, 2'b00};
    bsqx = {2'b00, bsq2_q};
    diff = {1'b0, bsqx} - {1'b0, l4};
    if (acneg2_q) begin
      disc_d = bsqx + l4;
      dneg_d = 1'b0;
    end else if (diff[qes_pkg::DiscBits]) begin
      disc_d = l4 - bsqx;
      dneg_d = 1'b1;
    end else begin
      disc_d = diff[qes_pkg::DiscBits-1:0];
      dneg_d = 1'b0;
    end
  end

  logic                         vld3_q;
  logic [qes_pkg::DiscBits-1:0] disc3_q;
  logic                         dneg3_q;
  logic [W-1:0]                 bb3_q, c3_q, ma3_q, mb3_q;
  logic                         as3_q, az3_q, bz3_q, cz3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld3_q <= 1'b0;
    end else if (en) begin
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      disc3_q <= disc_d;
      dneg3_q <= dneg_d;
      bb3_q   <= bb2_q;
      c3_q    <= c2_q;
      ma3_q   <= ma2_q;
      mb3_q   <= mb2_q;
      as3_q   <= as2_q;
      az3_q   <= az2_q;
      bz3_q   <= bz2_q;
      cz3_q   <= cz2_q;
    end
  end

  // case selection: outcome and division operands
  qes_pkg::sol_t sol3;
  logic          dz3;

  always_comb begin
    dz3             = (disc3_q[qes_pkg::DiscBits-1:2*W] == '0)
                      && (disc3_q[2*W-1:0] <= (2*W)'(disc_tol_q));
    sol3            = '0;
    sol3.outcome    = qes_pkg::OUT_NONE;
    sol3.zero_roots = 1'b1;
    if (az3_q) begin
      // linear equation
      if (cz3_q) begin
        sol3.outcome = bz3_q ? qes_pkg::OUT_ALL : qes_pkg::OUT_ONE;
      end else if (!bz3_q) begin
        sol3.outcome    = qes_pkg::OUT_ONE;
        sol3.zero_roots = 1'b0;
        sol3.nb         = -{c3_q[W-1], c3_q};
        sol3.den_neg    = bb3_q[W-1];
        sol3.den_mag    = {1'b0, mb3_q};
      end
    end else if (bz3_q && cz3_q) begin
      sol3.outcome = qes_pkg::OUT_ONE;
    end else if (dz3 || !dneg3_q) begin
      // double root or two roots over 2a
      sol3.outcome    = dz3 ? qes_pkg::OUT_ONE : qes_pkg::OUT_TWO;
      sol3.zero_roots = 1'b0;
      sol3.use_s      = !dz3;
      sol3.nb         = -{bb3_q[W-1], bb3_q};
      sol3.den_neg    = as3_q;
      sol3.den_mag    = {ma3_q, 1'b0};
    end
  end

  // ---------------------------------------------------------------- sqrt chain
  logic                         sq_vld  [NC+1];
  logic [qes_pkg::SremBits-1:0] sq_rem  [NC+1];
  logic [qes_pkg::RootBits-1:0] sq_root [NC+1];
  logic [qes_pkg::DiscBits-1:0] sq_disc [NC+1];
  qes_pkg::sol_t                sq_sol  [NC+1];

  assign sq_vld[0]  = vld3_q;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_disc[0] = disc3_q;
  assign sq_sol[0]  = sol3;

  for (genvar j = 0; j < NC; j++) begin : g_sqrt
    qes_sqrt_cell #(
      .PairIdx (NC - 1 - j)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (sq_vld[j]),
      .rem_i  (sq_rem[j]),
      .root_i (sq_root[j]),
      .disc_i (sq_disc[j]),
      .sol_i  (sq_sol[j]),
      .vld_o  (sq_vld[j+1]),
      .rem_o  (sq_rem[j+1]),
      .root_o (sq_root[j+1]),
      .disc_o (sq_disc[j+1]),
      .sol_o  (sq_sol[j+1])
    );
  end

  // ---------------------------------------------------------------- numerators
  qes_pkg::sol_t                sol_s;
  logic [qes_pkg::RootBits-1:0] s_eff;
  logic signed [NC+2:0]         num1, num2;
  qes_pkg::div_t                prep_d;

  assign sol_s = sq_sol[NC];
  assign s_eff = sol_s.use_s ? sq_root[NC] : '0;

  // -b +/- sqrt(d) as sign and magnitude
  always_comb begin
    num1               = (NC+3)'(sol_s.nb) + $signed({3'b000, s_eff});
    num2               = (NC+3)'(sol_s.nb) - $signed({3'b000, s_eff});
    prep_d             = '0;
    prep_d.outcome     = sol_s.outcome;
    prep_d.zero_roots  = sol_s.zero_roots;
    prep_d.dm          = sol_s.den_mag;
    prep_d.neg1        = num1[NC+2] ^ sol_s.den_neg;
    prep_d.neg2        = num2[NC+2] ^ sol_s.den_neg;
    prep_d.nm1         = qes_pkg::NumBits'(num1[NC+2] ? -num1 : num1);
    prep_d.nm2         = qes_pkg::NumBits'(num2[NC+2] ? -num2 : num2);
  end

  logic          vldp_q;
  qes_pkg::div_t prep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vldp_q <= 1'b0;
    end else if (en) begin
      vldp_q <= sq_vld[NC];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prep_q <= prep_d;
    end
  end

  // ---------------------------------------------------------------- divider chain
  logic          dv_vld [ND+1];
  qes_pkg::div_t dv     [ND+1];
  qes_pkg::div_t dv_in;

  // integer part overflow check and first partial remainder
  always_comb begin
    dv_in      = prep_q;
    dv_in.pre1 = (qes_pkg::NumBits+W+2)'(prep_q.nm1)
                 >= (qes_pkg::NumBits+W+2)'({prep_q.dm, {qes_pkg::FracBits{1'b0}}});
    dv_in.pre2 = (qes_pkg::NumBits+W+2)'(prep_q.nm2)
                 >= (qes_pkg::NumBits+W+2)'({prep_q.dm, {qes_pkg::FracBits{1'b0}}});
    dv_in.rem1 = qes_pkg::DremBits'(prep_q.nm1 >> qes_pkg::FracBits);
    dv_in.rem2 = qes_pkg::DremBits'(prep_q.nm2 >> qes_pkg::FracBits);
  end

  assign dv_vld[0] = vldp_q;
  assign dv[0]     = dv_in;

  for (genvar j = 0; j < ND; j++) begin : g_div
    qes_div_cell #(
      .BitIdx (ND - 1 - j)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (dv_vld[j]),
      .div_i  (dv[j]),
      .vld_o  (dv_vld[j+1]),
      .div_o  (dv[j+1])
    );
  end

  // ---------------------------------------------------------------- saturation
  qes_pkg::div_t dres;
  logic [W-1:0]  lim1, lim2, qv1, qv2;
  logic          sat1, sat2, den_zero;
  logic [W-1:0]  root1_d, root2_d;
  logic          ovf_d;

  assign dres = dv[ND];

  always_comb begin
    den_zero = dres.dm == '0;
    lim1     = dres.neg1 ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    lim2     = dres.neg2 ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    sat1     = dres.pre1 || (dres.q1 > lim1);
    sat2     = dres.pre2 || (dres.q2 > lim2);
    qv1      = sat1 ? lim1 : dres.q1;
    qv2      = sat2 ? lim2 : dres.q2;
    if (dres.zero_roots || den_zero) begin
      root1_d = '0;
      root2_d = '0;
      ovf_d   = 1'b0;
    end else begin
      root1_d = dres.neg1 ? (~qv1 + 1'b1) : qv1;
      root2_d = dres.neg2 ? (~qv2 + 1'b1) : qv2;
      ovf_d   = sat1 || sat2;
    end
  end

  // ---------------------------------------------------------------- output
  logic [W-1:0] root1_q, root2_q;
  logic [1:0]   outcome_q;
  logic         ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_vld[ND];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      root1_q   <= root1_d;
      root2_q   <= root2_d;
      outcome_q <= dres.outcome;
      ovf_q     <= ovf_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {root2_q, root1_q};
  assign m_axis_tuser  = {ovf_q, outcome_q};

  // ---------------------------------------------------------------- checks
  // no root or every x: roots and flag cleared
  a_no_root_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (outcome_q == qes_pkg::OUT_NONE || outcome_q == qes_pkg::OUT_ALL)
    |-> (root1_q == '0) && (root2_q == '0) && !ovf_q)
    else $error("roots not cleared without a root");

  // a single root shows in both fields
  a_single_root : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (outcome_q == qes_pkg::OUT_ONE) |-> root1_q == root2_q)
    else $error("single root differs between fields");

  // saturation only where a root was computed
  a_ovf_outcome : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && ovf_q
    |-> (outcome_q == qes_pkg::OUT_ONE || outcome_q == qes_pkg::OUT_TWO))
    else $error("overflow without a root");

  // a held result keeps the chain frozen
  a_hold_chain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !m_axis_tready |=> $stable(dv_vld[ND]) && $stable(vld1_q))
    else $error("chain moved during a stall");

endmodule

### dv/qes_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qes_checker
// watches the equation and result channels of the quadratic equation solver,
// works out the expected roots of each accepted equation and compares them
// field by field with the results in arrival order
// ----------------------------------------------------------------------------
module qes_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,    // coef_quad, coef_lin, coef_const
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,    // root_first, root_second
  input  logic [2:0]  m_axis_tuser,    // outcome[1:0], overflow
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [1:0]  outcome;
    logic [31:0] root_first;
    logic [31:0] root_second;
    logic        overflow;
  } roots_t;

  roots_t      expected_roots[$];
  logic [15:0] coef_tol;
  logic [31:0] disc_tol;
  int          fails;

  assign fail_count_o = fails;

  function automatic logic [63:0] magn64(input longint x);
    magn64 = x < 0 ? 64'(-x) : 64'(x);
  endfunction

  // quotient truncated toward zero, saturated to the word range
  function automatic longint sat_div(input longint num, input longint den,
                                     inout logic ovf);
    logic        neg;
    logic [63:0] nm, dm, lim, ip, rem, q;
    neg = (num < 0) != (den < 0);
    nm  = magn64(num);
    dm  = magn64(den);
    lim = (64'd1 << 31) - (neg ? 64'd0 : 64'd1);
    if (dm == 0) return 0;
    ip  = nm / dm;
    rem = nm % dm;
    if (ip > (lim >> 16)) begin
      q   = lim;
      ovf = 1'b1;
    end else begin
      q = (ip << 16) + ((rem << 16) / dm);
      if (q > lim) begin
        q   = lim;
        ovf = 1'b1;
      end
    end
    return neg ? -longint'(q) : longint'(q);
  endfunction

  // floor square root of a 66-bit magnitude
  function automatic logic [63:0] floor_sqrt(input logic [65:0] d);
    logic [67:0] acc, cand;
    logic [63:0] r;
    r   = 0;
    acc = 0;
    for (int i = 32; i >= 0; i--) begin
      acc  = (acc << 2) | 68'(d[2*i +: 2]);
      cand = 68'((r << 2) | 64'd1);
      if (acc >= cand) begin
        acc = acc - cand;
        r   = (r << 1) | 64'd1;
      end else begin
        r = r << 1;
      end
    end
    return r;
  endfunction

  function automatic roots_t solve_roots(input logic [95:0] coefs);
    longint        a, b, c, bb;
    logic          az, bz, cz, ovf, dneg;
    logic signed [67:0] disc;
    logic [65:0]   dmag;
    longint        s;
    roots_t        res;
    a  = longint'($signed(coefs[31:0]));
    b  = longint'($signed(coefs[63:32]));
    c  = longint'($signed(coefs[95:64]));
    az = magn64(a) <= coef_tol;
    bz = magn64(b) <= coef_tol;
    cz = magn64(c) <= coef_tol;
    ovf = 1'b0;
    res = '0;
    res.outcome = qes_pkg::OUT_NONE;
    if (az) begin
      if (cz) begin
        res.outcome = bz ? qes_pkg::OUT_ALL : qes_pkg::OUT_ONE;
      end else if (!bz) begin
        res.outcome    = qes_pkg::OUT_ONE;
        res.root_first = 32'(sat_div(-c, b, ovf));
        res.root_second = res.root_first;
      end
    end else if (bz && cz) begin
      res.outcome = qes_pkg::OUT_ONE;
    end else begin
      bb   = bz ? 0 : b;
      disc = 68'(bb) * 68'(bb) - 68'sd4 * 68'(a) * 68'(c);
      dneg = disc < 0;
      dmag = 66'(dneg ? -disc : disc);
      if (dmag <= 66'(disc_tol)) begin
        res.outcome     = qes_pkg::OUT_ONE;
        res.root_first  = 32'(sat_div(-bb, 2 * a, ovf));
        res.root_second = res.root_first;
      end else if (!dneg) begin
        s = longint'(floor_sqrt(dmag));
        res.outcome     = qes_pkg::OUT_TWO;
        res.root_first  = 32'(sat_div(-bb + s, 2 * a, ovf));
        res.root_second = 32'(sat_div(-bb - s, 2 * a, ovf));
      end
    end
    res.overflow = ovf;
    return res;
  endfunction

  // register shadow, equation intake and result comparison
  always @(posedge clk_i or negedge rst_ni) begin
    roots_t want;
    if (!rst_ni) begin
      coef_tol  <= '0;
      disc_tol  <= '0;
      fails     <= 0;
      pending_o <= 0;
      expected_roots.delete();
    end else begin
      if (psel && penable && pwrite) begin
        if (paddr[2] == qes_pkg::REG_COEF_TOL) coef_tol <= pwdata[15:0];
        else                                   disc_tol <= pwdata;
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_roots.push_back(solve_roots(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_roots.size() == 0) begin
          $error("result item with no equation waiting");
          fails <= fails + 1;
        end else begin
          want = expected_roots.pop_front();
          if (m_axis_tuser[1:0] !== want.outcome ||
              m_axis_tdata[31:0] !== want.root_first ||
              m_axis_tdata[63:32] !== want.root_second ||
              m_axis_tuser[2] !== want.overflow)
            fails <= fails + 1;
          if (m_axis_tuser[1:0] !== want.outcome)
            $error("outcome: expected %0d, got %0d", want.outcome, m_axis_tuser[1:0]);
          if (m_axis_tdata[31:0] !== want.root_first)
            $error("root_first: expected %h, got %h", want.root_first,
                   m_axis_tdata[31:0]);
          if (m_axis_tdata[63:32] !== want.root_second)
            $error("root_second: expected %h, got %h", want.root_second,
                   m_axis_tdata[63:32]);
          if (m_axis_tuser[2] !== want.overflow)
            $error("overflow: expected %0d, got %0d", want.overflow, m_axis_tuser[2]);
        end
      end
      pending_o <= expected_roots.size();
    end
  end

endmodule

### dv/quadratic_equation_solver_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_equation_solver_core_test
// drives equations with bursty gaps and a stalling result side through
// several tolerance settings; the checker predicts and compares the roots
// ----------------------------------------------------------------------------
module quadratic_equation_solver_core_test;

  localparam int Latency   = 70;
  localparam int StallLimit = 20000;

  logic        clk_i, rst_ni;
  logic        s_axis_tvalid, s_axis_tready;
  logic [95:0] s_axis_tdata;
  logic        m_axis_tvalid, m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  int          fail_count, pending;
  logic        hold_off;
  int          idle_cycles;

  quadratic_equation_solver_core uut (.*);

  qes_checker checker_i (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // receiver stall pattern, with one long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_off) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
    end
  end

  // watchdog on stretches with no item moving
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready) || hold_off) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > StallLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic reg_write(input logic addr_hi, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {addr_hi, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_equation(input logic [31:0] a, input logic [31:0] b,
                               input logic [31:0] c);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {c, b, a};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic pause_sender;
    s_axis_tvalid <= 1'b0;
    repeat ($urandom_range(1, 12)) @(posedge clk_i);
  endtask

  task automatic drain_results;
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 5) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coef(input int mode);
    case (mode)
      0:       rand_coef = $urandom();
      1:       rand_coef = 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff);
      2:       rand_coef = 32'($signed($urandom_range(0, 200)) - 100);
      default: rand_coef = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
    endcase
  endfunction

  task automatic random_phase(input int count);
    int sent, burst, m;
    logic [31:0] a, b, c, r;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 30);
      for (int k = 0; k < burst && sent < count; k++) begin
        m = $urandom_range(0, 9);
        a = rand_coef(m < 4 ? 0 : (m < 8 ? 1 : $urandom_range(2, 3)));
        b = rand_coef($urandom_range(0, 3));
        c = rand_coef($urandom_range(0, 3));
        // perfect-square families give single and close double roots
        if (m == 9) begin
          r = rand_coef(2);
          b = 32'($signed(a[20:0]) * 2);
          c = 32'($signed(b[15:0]) * $signed(b[15:0]) / ($signed(a[20:0]) * 4 + 1));
          if (r[0]) a = 32'($signed(r));
        end
        send_equation(a, b, c);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) pause_sender();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    hold_off = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, linear cases, shortcuts, saturation
    send_equation(32'h0, 32'h0, 32'h0);
    send_equation(32'h0, 32'h00010000, 32'h0);
    send_equation(32'h0, 32'h0, 32'h00010000);
    send_equation(32'h0, 32'h00020000, 32'hfffa0000);
    send_equation(32'h0, 32'h00000001, 32'h7fffffff);
    send_equation(32'h0, 32'h80000000, 32'h80000000);
    send_equation(32'h00010000, 32'h0, 32'h0);
    send_equation(32'h00010000, 32'h0, 32'hfffc0000);
    send_equation(32'h00010000, 32'h0, 32'h00040000);
    send_equation(32'h00010000, 32'h00020000, 32'h00010000);
    send_equation(32'h00010000, 32'hfffd0000, 32'h00020000);
    send_equation(32'h80000000, 32'h80000000, 32'h80000000);
    send_equation(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_equation(32'h80000000, 32'h7fffffff, 32'h80000000);
    send_equation(32'h00000001, 32'h7fffffff, 32'h00000001);
    send_equation(32'hffffffff, 32'h80000000, 32'h7fffffff);
    send_equation(32'h00000001, 32'h0, 32'h80000000);
    send_equation(32'hffffffff, 32'h00000002, 32'hffffffff);
    send_equation(32'h00000005, 32'h00000001, 32'h00000003);
    send_equation(32'hfffffffb, 32'hffffffff, 32'h00000002);
    drain_results();

    // tolerances near the top
    reg_write(qes_pkg::REG_COEF_TOL, 32'h0000ffff);
    reg_write(qes_pkg::REG_DISC_TOL, 32'hffffffff);
    send_equation(32'h0000ffff, 32'h00010000, 32'hffff0001);
    send_equation(32'h00010000, 32'h0000ffff, 32'h00000000);
    send_equation(32'h00010000, 32'h00000000, 32'h00010000);
    send_equation(32'h00010001, 32'h00020002, 32'h00010001);
    random_phase(250);
    drain_results();

    // long receiver hold-off while the sender keeps offering
    reg_write(qes_pkg::REG_COEF_TOL, 32'h00000003);
    reg_write(qes_pkg::REG_DISC_TOL, 32'h00001000);
    fork
      begin
        hold_off <= 1'b1;
        repeat (300) @(posedge clk_i);
        hold_off <= 1'b0;
      end
      random_phase(250);
    join
    drain_results();

    reg_write(qes_pkg::REG_COEF_TOL, 32'h0);
    reg_write(qes_pkg::REG_DISC_TOL, 32'h0);
    random_phase(350);
    drain_results();

    reg_write(qes_pkg::REG_COEF_TOL, 32'h00000064);
    reg_write(qes_pkg::REG_DISC_TOL, $urandom());
    random_phase(330);
    drain_results();

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
